### sv/gru_pkg.sv
// Shared types and constants for the Givens rotation unit.
`timescale 1ns / 1ps
package gru_pkg;
    localparam int unsigned DataW  = 32;
    localparam int unsigned CsFrac = 30;
    localparam logic [DataW-1:0] CsOne = 32'h4000_0000;
    localparam logic [DataW-1:0] DataMax = 32'h7FFF_FFFF;
    localparam logic [DataW-1:0] DataMin = 32'h8000_0000;

    localparam logic KindLoad   = 1'b0;
    localparam logic KindRotate = 1'b1;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_NORM = 8'b0000_0010,
        S_SQ   = 8'b0000_0100,
        S_ROOT = 8'b0000_1000,
        S_DIVC = 8'b0001_0000,
        S_DIVS = 8'b0010_0000,
        S_ROT  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;
endpackage

### sv/gru_mul.sv
// Shared registered signed multiplier.
`timescale 1ns / 1ps
module gru_mul (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [65:0] o_p
);
    logic signed [65:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule

### sv/gru_sqrt.sv
// Bit-serial integer square root of a 64-bit radicand, one result bit per cycle.
`timescale 1ns / 1ps
module gru_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_radicand,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [63:0] r_n, n_n;
    logic [63:0] r_res, n_res;
    logic [63:0] r_bit, n_bit;
    logic [63:0] trial;

    assign trial = r_res + r_bit;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_n    = r_n;
        n_res  = r_res;
        n_bit  = r_bit;
        if (i_start) begin
            n_busy = 1'b1;
            n_n    = i_radicand;
            n_res  = 64'd0;
            n_bit  = 64'd1 << 62;
        end else if (r_busy) begin
            if (r_n >= trial) begin
                n_n   = r_n - trial;
                n_res = (r_res >> 1) + r_bit;
            end else begin
                n_res = r_res >> 1;
            end
            n_bit = r_bit >> 2;
            if (r_bit[0]) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_n   <= n_n;
        r_res <= n_res;
        r_bit <= n_bit;
    end

    assign o_done = r_done;
    assign o_root = r_res[31:0];
endmodule

### sv/gru_div.sv
// Restoring divider for round(m * 2^30 / r), one quotient bit per cycle.
`timescale 1ns / 1ps
module gru_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_mag,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [30:0] o_quot
);
    import gru_pkg::*;

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_cnt, n_cnt;
    logic [31:0] r_rem, n_rem;
    logic [30:0] r_lo, n_lo;
    logic [31:0] r_den, n_den;
    logic [61:0] num;
    logic [32:0] trial;

    // Rounding is folded in by adding half the divisor to the dividend.
    assign num   = {i_mag, {CsFrac{1'b0}}} + {31'd0, i_den[31:1]};
    assign trial = {r_rem, r_lo[30]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_lo   = r_lo;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 5'd31;
            n_rem  = {1'b0, num[61:31]};
            n_lo   = num[30:0];
            n_den  = i_den;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_den}) begin
                n_rem = 32'(trial - {1'b0, r_den});
                n_lo  = {r_lo[29:0], 1'b1};
            end else begin
                n_rem = trial[31:0];
                n_lo  = {r_lo[29:0], 1'b0};
            end
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_lo  <= n_lo;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_lo;
endmodule

### sv/givens_rotation_unit.sv
// Givens rotation unit: sequencer, rotation registers and output stage.
//
// Input channel: i_valid / o_stall with i_kind, i_first_value, i_second_value.
// A transaction with kind 0 loads an (x, y) pair and computes cosine and sine
// in Q1.30; kind 1 rotates a Q15.16 pair (a, b) by the stored rotation.
// Output channel: o_valid / i_stall with o_first_result, o_second_result and
// o_saturated. Every input transaction gives exactly one output transaction.
// A rotate passes through the rotate steps, which feed four products through
// the one shared 33x33 multiplier, and the output stage, which writes the
// result; the next transaction is taken once the block is back in idle. A
// load passes through one-bit normalizing shifts, the squares, the bit-serial
// root and the two divisions, then the output stage writes the result. An
// all-zero load skips them and writes the identity rotation.
// The block holds o_stall high from acceptance until its result is written
// into the output register. A finished result waits there while the receiver
// stalls; a new transaction may be accepted meanwhile, and its result waits
// in the sequencer until the register is free.
// Reset (synchronous, active low) empties the pipeline and sets the rotation
// to identity, so rotates before any load pass the pair through.
`timescale 1ns / 1ps
module givens_rotation_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [31:0] i_first_value,
    input  logic [31:0] i_second_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_first_result,
    output logic [31:0] o_second_result,
    output logic        o_saturated
);
    import gru_pkg::*;

    t_state r_state, n_state;
    logic [2:0]  r_step, n_step;
    logic [31:0] r_x, n_x, r_y, n_y;
    logic        r_xneg, n_xneg, r_yneg, n_yneg;
    logic [31:0] r_a, n_a, r_b, n_b;
    logic [63:0] r_acc0, n_acc0, r_acc1, n_acc1;
    logic [31:0] r_cos, n_cos, r_sin, n_sin;
    logic [31:0] r_root, n_root;
    logic [30:0] r_qc, n_qc;
    logic        r_rot, n_rot;
    logic        r_sqrt_go, n_sqrt_go, r_div_go, n_div_go;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_first, n_out_first, r_out_second, n_out_second;
    logic        r_out_sat, n_out_sat;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [63:0] prod;
    logic        sqrt_done, div_done;
    logic [31:0] sqrt_root;
    logic [30:0] div_quot;
    logic        accept, out_free;
    logic [31:0] abs_first, abs_second;
    logic [33:0] rot0, rot1;
    logic [31:0] res0, res1;
    logic        sat0, sat1;

    assign accept    = i_valid && !o_stall;
    assign out_free  = !r_out_valid || !i_stall;
    assign prod      = mul_p[63:0];
    assign abs_first  = i_first_value[31] ? 32'(-i_first_value) : i_first_value;
    assign abs_second = i_second_value[31] ? 32'(-i_second_value) : i_second_value;

    // Rounded scale by 2^-30: add half an LSB and keep the upper bits.
    assign rot0 = 34'((r_acc0 + 64'(CsOne >> 1)) >> CsFrac);
    assign rot1 = 34'((r_acc1 + 64'(CsOne >> 1)) >> CsFrac);
    assign sat0 = (rot0[33:31] != 3'b000) && (rot0[33:31] != 3'b111);
    assign sat1 = (rot1[33:31] != 3'b000) && (rot1[33:31] != 3'b111);
    assign res0 = sat0 ? (rot0[33] ? DataMin : DataMax) : rot0[31:0];
    assign res1 = sat1 ? (rot1[33] ? DataMin : DataMax) : rot1[31:0];

    always_comb begin
        mul_a = {1'b0, r_x};
        mul_b = {1'b0, r_x};
        if (r_state == S_SQ) begin
            if (r_step != 3'd0) begin
                mul_a = {1'b0, r_y};
                mul_b = {1'b0, r_y};
            end
        end else begin
            case (r_step)
                3'd0: begin
                    mul_a = {r_cos[31], r_cos};
                    mul_b = {r_a[31], r_a};
                end
                3'd1: begin
                    mul_a = {r_sin[31], r_sin};
                    mul_b = {r_b[31], r_b};
                end
                3'd2: begin
                    mul_a = {r_cos[31], r_cos};
                    mul_b = {r_b[31], r_b};
                end
                default: begin
                    mul_a = {r_sin[31], r_sin};
                    mul_b = {r_a[31], r_a};
                end
            endcase
        end
    end

    gru_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    gru_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_sqrt_go),
        .i_radicand (r_acc0),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    gru_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_mag   ((r_state == S_DIVS) ? r_y : r_x),
        .i_den   (r_root),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_x          = r_x;
        n_y          = r_y;
        n_xneg       = r_xneg;
        n_yneg       = r_yneg;
        n_a          = r_a;
        n_b          = r_b;
        n_acc0       = r_acc0;
        n_acc1       = r_acc1;
        n_cos        = r_cos;
        n_sin        = r_sin;
        n_root       = r_root;
        n_qc         = r_qc;
        n_rot        = r_rot;
        n_sqrt_go    = 1'b0;
        n_div_go     = 1'b0;
        n_out_valid  = r_out_valid && i_stall;
        n_out_first  = r_out_first;
        n_out_second = r_out_second;
        n_out_sat    = r_out_sat;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_step = 3'd0;
                    n_a    = i_first_value;
                    n_b    = i_second_value;
                    n_x    = abs_first;
                    n_y    = abs_second;
                    n_xneg = i_first_value[31];
                    n_yneg = i_second_value[31];
                    if (i_kind == KindRotate) begin
                        n_rot   = 1'b1;
                        n_state = S_ROT;
                    end else if ((abs_first | abs_second) == 32'd0) begin
                        n_cos   = CsOne;
                        n_sin   = 32'd0;
                        n_rot   = 1'b0;
                        n_state = S_OUT;
                    end else begin
                        n_rot   = 1'b0;
                        n_state = S_NORM;
                    end
                end
            end
            S_NORM: begin
                // The larger magnitude reaches 2^30 when either top bit is set.
                if ((r_x[31:30] | r_y[31:30]) != 2'b00) begin
                    n_state = S_SQ;
                end else begin
                    n_x = {r_x[30:0], 1'b0};
                    n_y = {r_y[30:0], 1'b0};
                end
            end
            S_SQ: begin
                n_step = r_step + 3'd1;
                if (r_step == 3'd1) begin
                    n_acc0 = prod;
                end else if (r_step == 3'd2) begin
                    n_acc0    = r_acc0 + prod;
                    n_sqrt_go = 1'b1;
                    n_state   = S_ROOT;
                end
            end
            S_ROOT: begin
                if (sqrt_done) begin
                    n_root   = sqrt_root;
                    n_div_go = 1'b1;
                    n_state  = S_DIVC;
                end
            end
            S_DIVC: begin
                if (div_done) begin
                    n_qc     = div_quot;
                    n_div_go = 1'b1;
                    n_state  = S_DIVS;
                end
            end
            S_DIVS: begin
                if (div_done) begin
                    n_cos   = r_xneg ? 32'(-{1'b0, r_qc}) : {1'b0, r_qc};
                    n_sin   = r_yneg ? 32'(-{1'b0, div_quot}) : {1'b0, div_quot};
                    n_state = S_OUT;
                end
            end
            S_ROT: begin
                n_step = r_step + 3'd1;
                case (r_step)
                    3'd1:    n_acc0 = prod;
                    3'd2:    n_acc0 = r_acc0 + prod;
                    3'd3:    n_acc1 = prod;
                    3'd4: begin
                        n_acc1  = r_acc1 - prod;
                        n_state = S_OUT;
                    end
                    default: n_acc0 = r_acc0;
                endcase
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_rot) begin
                        n_out_first  = res0;
                        n_out_second = res1;
                        n_out_sat    = sat0 || sat1;
                    end else begin
                        n_out_first  = r_cos;
                        n_out_second = r_sin;
                        n_out_sat    = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= 3'd0;
            r_cos       <= CsOne;
            r_sin       <= 32'd0;
            r_rot       <= 1'b0;
            r_sqrt_go   <= 1'b0;
            r_div_go    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_cos       <= n_cos;
            r_sin       <= n_sin;
            r_rot       <= n_rot;
            r_sqrt_go   <= n_sqrt_go;
            r_div_go    <= n_div_go;
            r_out_valid <= n_out_valid;
        end
        r_x          <= n_x;
        r_y          <= n_y;
        r_xneg       <= n_xneg;
        r_yneg       <= n_yneg;
        r_a          <= n_a;
        r_b          <= n_b;
        r_acc0       <= n_acc0;
        r_acc1       <= n_acc1;
        r_root       <= n_root;
        r_qc         <= n_qc;
        r_out_first  <= n_out_first;
        r_out_second <= n_out_second;
        r_out_sat    <= n_out_sat;
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_first_result  = r_out_first;
    assign o_second_result = r_out_second;
    assign o_saturated     = r_out_sat;

`ifndef SYNTH
    a_sqrt_go_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sqrt_go |-> (r_state == S_ROOT))
        else $error("root started outside the root phase");
    a_div_go_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_go |-> ((r_state == S_DIVC) || (r_state == S_DIVS)))
        else $error("division started outside a division phase");
    a_cos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($signed(r_cos) <= $signed(CsOne)) && ($signed(r_cos) >= -$signed(CsOne)))
        else $error("stored cosine exceeds unit magnitude");
    a_norm_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQ) |-> ((r_x[31:30] | r_y[31:30]) != 2'b00))
        else $error("squares taken before normalization finished");
`endif
endmodule
